[src/lgs_pkg.sv]
package lgs_pkg;

	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int COL_W     = $clog2(GRID_COLS);
	localparam int CNT_W     = 7;
	localparam int RAM_AW    = ROW_W + 1;
	localparam int RAM_DEPTH = 2 * GRID_ROWS;

	localparam logic [1:0] EDGE_DEAD  = 2'd0;
	localparam logic [1:0] EDGE_TORUS = 2'd1;
	localparam logic [1:0] EDGE_KLEIN = 2'd2;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;

	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;
	localparam logic [1:0] CFG_EDGE = 2'd2;

	typedef logic [GRID_COLS-1:0] row_word_t;

	// neighborhood control for one row update
	typedef struct packed {
		logic [1:0]       edge_mode;
		logic [CNT_W-1:0] cols;
		logic             top_cross;
		logic             bot_cross;
		logic             row_active;
	} row_ctl_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] hi);
		if (v < CNT_W'(3))
			return CNT_W'(3);
		else if (v > hi)
			return hi;
		else
			return v;
	endfunction

endpackage

[src/lgs_ram.sv]
module lgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[src/lgs_row_calc.sv]
module lgs_row_calc (
	input  lgs_pkg::row_word_t top,
	input  lgs_pkg::row_word_t mid,
	input  lgs_pkg::row_word_t bot,
	input  lgs_pkg::row_ctl_t  ctl,
	output lgs_pkg::row_word_t next_row
);
	import lgs_pkg::*;

	row_word_t top_v, bot_v, klein_top, klein_bot;
	row_word_t tl, tr, ml, mr, bl, br;
	logic      wrap_cols;
	logic [CNT_W-1:0] cm1;

	// klein crossing: column c maps to cols - c, column 0 stays
	function automatic row_word_t klein_map(input row_word_t w, input logic [CNT_W-1:0] n);
		row_word_t        o;
		logic [CNT_W-1:0] idx;
		o = '0;
		for (int c = 0; c < GRID_COLS; c++) begin
			idx = n - CNT_W'(c);
			if (c == 0)
				o[c] = w[0];
			else if (CNT_W'(c) < n)
				o[c] = w[idx[COL_W-1:0]];
		end
		return o;
	endfunction

	assign klein_top = klein_map(top, ctl.cols);
	assign klein_bot = klein_map(bot, ctl.cols);
	assign wrap_cols = (ctl.edge_mode == EDGE_TORUS) || (ctl.edge_mode == EDGE_KLEIN);
	assign cm1       = ctl.cols - CNT_W'(1);

	always_comb begin
		top_v = top;
		bot_v = bot;
		if (ctl.top_cross) begin
			if (ctl.edge_mode == EDGE_KLEIN)
				top_v = klein_top;
			else if (ctl.edge_mode != EDGE_TORUS)
				top_v = '0;
		end
		if (ctl.bot_cross) begin
			if (ctl.edge_mode == EDGE_KLEIN)
				bot_v = klein_bot;
			else if (ctl.edge_mode != EDGE_TORUS)
				bot_v = '0;
		end
	end

	always_comb begin
		for (int c = 0; c < GRID_COLS; c++) begin
			if (c == 0) begin
				tl[c] = wrap_cols & top_v[cm1[COL_W-1:0]];
				ml[c] = wrap_cols & mid[cm1[COL_W-1:0]];
				bl[c] = wrap_cols & bot_v[cm1[COL_W-1:0]];
			end else begin
				tl[c] = top_v[c-1];
				ml[c] = mid[c-1];
				bl[c] = bot_v[c-1];
			end
			if (CNT_W'(c) == cm1 || c == GRID_COLS - 1) begin
				tr[c] = wrap_cols & top_v[0];
				mr[c] = wrap_cols & mid[0];
				br[c] = wrap_cols & bot_v[0];
			end else begin
				tr[c] = top_v[c+1];
				mr[c] = mid[c+1];
				br[c] = bot_v[c+1];
			end
		end
	end

	always_comb begin
		logic [3:0] sum;
		for (int c = 0; c < GRID_COLS; c++) begin
			sum = 4'(tl[c]) + 4'(top_v[c]) + 4'(tr[c]) + 4'(ml[c]) + 4'(mr[c])
				+ 4'(bl[c]) + 4'(bot_v[c]) + 4'(br[c]);
			if (!ctl.row_active || CNT_W'(c) >= ctl.cols)
				next_row[c] = mid[c];
			else if (sum == 4'd3)
				next_row[c] = 1'b1;
			else if (sum == 4'd2)
				next_row[c] = mid[c];
			else
				next_row[c] = 1'b0;
		end
	end

endmodule

[src/life_generation_step.sv]
// Game of life engine, rule B3/S23, grid of 64 rows by 64 cells in one RAM.
// Write and read of a cell: row read at transfer, result registered in ST_CELL.
// Generation per row: three RAM reads on one read port, then the write-back.
// One item at a time; next item taken once the result transfer is done.
// Reset (arst_n low) restores config defaults, then a pass clears every row of
// the live bank while s_axis_tready stays low.
module life_generation_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // mode[1:0], row[7:2], col[13:8], cell_in[14]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // cell_out[0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import lgs_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CELL  = 3'd2;
	localparam logic [2:0] ST_GEN   = 3'd3;

	logic [2:0]       state_q;
	logic [ROW_W-1:0] clr_q, gen_row_q, row_q;
	logic [COL_W-1:0] col_q;
	logic             val_q, is_write_q, bank_q;
	logic [1:0]       phase_q;
	logic [CNT_W-1:0] row_count_q, col_count_q, rc, cc;
	logic [1:0]       edge_mode_q;
	logic             out_valid_q, out_bit_q;
	row_word_t        top_q, mid_q, rdata, wdata, next_row;
	logic             we;
	logic [RAM_AW-1:0] waddr, raddr;
	logic [ROW_W-1:0] top_idx, bot_idx, rc_m1;
	logic             top_cross, bot_cross;
	row_ctl_t         ctl;
	logic [1:0]       in_mode;
	logic             accept;

	assign in_mode       = s_axis_tdata[1:0];
	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_bit_q};

	assign rc    = clamp_count(row_count_q, CNT_W'(GRID_ROWS));
	assign cc    = clamp_count(col_count_q, CNT_W'(GRID_COLS));
	assign rc_m1 = ROW_W'(rc - CNT_W'(1));

	assign top_cross = (gen_row_q == '0);
	assign bot_cross = (gen_row_q == rc_m1);
	assign top_idx   = top_cross ? rc_m1 : gen_row_q - ROW_W'(1);
	assign bot_idx   = bot_cross ? '0 : gen_row_q + ROW_W'(1);

	assign ctl = '{edge_mode:  edge_mode_q,
	               cols:       cc,
	               top_cross:  top_cross,
	               bot_cross:  bot_cross,
	               row_active: CNT_W'(gen_row_q) < rc};

	lgs_row_calc u_calc (
		.top      (top_q),
		.mid      (mid_q),
		.bot      (rdata),
		.ctl      (ctl),
		.next_row (next_row)
	);

	lgs_ram #(.WIDTH(GRID_COLS), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		we    = 1'b0;
		waddr = {bank_q, row_q};
		wdata = rdata;
		raddr = {bank_q, s_axis_tdata[7:2]};
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = {1'b0, clr_q};
				wdata = '0;
			end
			ST_CELL: begin
				we           = is_write_q;
				wdata[col_q] = val_q;
			end
			ST_GEN: begin
				unique case (phase_q)
					2'd0: raddr = {bank_q, top_idx};
					2'd1: raddr = {bank_q, gen_row_q};
					2'd2: raddr = {bank_q, bot_idx};
					default: begin
						we    = 1'b1;
						waddr = {~bank_q, gen_row_q};
						wdata = next_row;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CNT_W'(64);
			col_count_q <= CNT_W'(64);
			edge_mode_q <= EDGE_TORUS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS: row_count_q <= cfg_data;
				CFG_COLS: col_count_q <= cfg_data;
				CFG_EDGE: edge_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			gen_row_q   <= '0;
			phase_q     <= '0;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_bit_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == ROW_W'(GRID_ROWS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						priority if (in_mode == OP_WRITE || in_mode == OP_READ) begin
							state_q <= ST_CELL;
						end else if (in_mode == OP_ADVANCE) begin
							state_q   <= ST_GEN;
							gen_row_q <= '0;
							phase_q   <= '0;
						end else begin
							out_valid_q <= 1'b1;
							out_bit_q   <= 1'b0;
						end
					end
				end
				ST_CELL: begin
					out_valid_q <= 1'b1;
					out_bit_q   <= is_write_q ? 1'b0 : rdata[col_q];
					state_q     <= ST_IDLE;
				end
				ST_GEN: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						gen_row_q <= gen_row_q + ROW_W'(1);
						if (gen_row_q == ROW_W'(GRID_ROWS - 1)) begin
							bank_q      <= ~bank_q;
							out_valid_q <= 1'b1;
							out_bit_q   <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers and row buffers
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q      <= s_axis_tdata[7:2];
			col_q      <= s_axis_tdata[13:8];
			val_q      <= s_axis_tdata[14];
			is_write_q <= (in_mode == OP_WRITE);
		end
		if (state_q == ST_GEN && phase_q == 2'd1)
			top_q <= rdata;
		if (state_q == ST_GEN && phase_q == 2'd2)
			mid_q <= rdata;
	end

endmodule

[test/tb_life_generation_step.sv]
module tb_life_generation_step;
	timeunit 1ns;
	timeprecision 1ps;

	import lgs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // mode[1:0], row[7:2], col[13:8], cell_in[14]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // cell_out[0]
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [6:0]  cfg_data;

	life_generation_step i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// model of the grid and the register file
	logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
	logic [6:0]           rows_reg;
	logic [6:0]           cols_reg;
	logic [1:0]           edge_reg;

	logic [7:0] cell_queue [$];
	int         err_count;
	bit         hold_long;
	bit         rand_sink;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int sat_count(logic [6:0] v, int hi);
		if (v < 7'd3)
			return 3;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic bit nb_cell(int r, int c, int nr, int nc, logic [1:0] em);
		int cw;
		if (em == EDGE_TORUS) begin
			r = (r + nr) % nr;
			c = (c + nc) % nc;
		end else if (em == EDGE_KLEIN) begin
			if (r < 0 || r >= nr) begin
				cw = (c + nc) % nc;
				r  = (r + nr) % nr;
				c  = (cw == 0) ? 0 : nc - cw;
			end else begin
				c = (c + nc) % nc;
			end
		end else begin
			if (r < 0 || r >= nr || c < 0 || c >= nc)
				return 1'b0;
		end
		return life_grid[r][c];
	endfunction

	task automatic step_generation();
		logic [GRID_COLS-1:0] nxt [GRID_ROWS];
		int nr;
		int nc;
		int sum;
		nr = sat_count(rows_reg, GRID_ROWS);
		nc = sat_count(cols_reg, GRID_COLS);
		nxt = life_grid;
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++) begin
				sum = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							sum += nb_cell(r + dr, c + dc, nr, nc, edge_reg);
				if (sum < 2 || sum > 3)
					nxt[r][c] = 1'b0;
				else if (sum == 3)
					nxt[r][c] = 1'b1;
			end
		life_grid = nxt;
	endtask

	task automatic predict_cell(logic [15:0] d);
		logic [1:0] op;
		logic [5:0] r;
		logic [5:0] c;
		logic [7:0] res;
		op  = d[1:0];
		r   = d[7:2];
		c   = d[13:8];
		res = 8'd0;
		if (op == OP_WRITE)
			life_grid[r][c] = d[14];
		else if (op == OP_READ)
			res[0] = life_grid[r][c];
		else if (op == OP_ADVANCE)
			step_generation();
		cell_queue.push_back(res);
	endtask

	// tvalid stays high after a transfer until the next item or an idle gap
	task automatic send_item(logic [1:0] op, int r, int c, bit v, bit no_gap = 0);
		logic [15:0] d;
		int          idle_n;
		d = {1'b0, v, 6'(c), 6'(r), op};
		idle_n = no_gap ? 0 : int'($urandom_range(0, 12));
		if (idle_n != 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 16'($urandom);
			repeat (idle_n) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		predict_cell(d);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (cell_queue.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ROWS)
			rows_reg = val;
		else if (idx == CFG_COLS)
			cols_reg = val;
		else if (idx == CFG_EDGE)
			edge_reg = val[1:0];
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		logic [7:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (cell_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
				err_count++;
			end else begin
				want = cell_queue.pop_front();
				if (m_axis_tdata[0] !== want[0]) begin
					$display("%0t: cell_out expected %0b actual %0b", $time, want[0],
						m_axis_tdata[0]);
					err_count++;
				end
			end
		end
	end

	initial begin
		int wait_cnt;
		int idle_n;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				m_axis_tready <= 1'b0;
				for (wait_cnt = 0; wait_cnt < 300; wait_cnt++)
					@(posedge clk);
				hold_long = 0;
			end else if (rand_sink) begin
				idle_n = int'($urandom_range(0, 12));
				if (idle_n != 0) begin
					m_axis_tready <= 1'b0;
					repeat (idle_n) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic test_edges_and_modes();
		send_item(OP_READ, 0, 0, 0);
		send_item(OP_WRITE, 0, 0, 1);
		send_item(OP_WRITE, 63, 63, 1);
		send_item(OP_READ, 0, 0, 0);
		send_item(OP_READ, 63, 63, 0);
		send_item(2'd3, 63, 63, 1);
		send_item(OP_WRITE, 63, 63, 0);
		// blinker across the torus seam
		send_item(OP_WRITE, 0, 63, 1);
		send_item(OP_WRITE, 0, 1, 1);
		send_item(OP_ADVANCE, 0, 0, 0);
		send_item(OP_READ, 63, 0, 0);
		send_item(OP_READ, 1, 0, 0);
		send_item(OP_READ, 0, 63, 0);
		send_item(OP_ADVANCE, 42, 21, 1);
		send_item(OP_READ, 0, 1, 0);
	endtask

	task automatic test_small_grids();
		write_reg(CFG_ROWS, 7'd3);
		write_reg(CFG_COLS, 7'd4);
		write_reg(CFG_EDGE, 7'(EDGE_KLEIN));
		send_item(OP_WRITE, 0, 1, 1);
		send_item(OP_WRITE, 1, 1, 1);
		send_item(OP_WRITE, 2, 3, 1);
		send_item(OP_ADVANCE, 0, 0, 0);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++)
				send_item(OP_READ, r, c, 0);
		write_reg(CFG_EDGE, 7'(EDGE_DEAD));
		write_reg(CFG_ROWS, 7'd0);
		write_reg(CFG_COLS, 7'd127);
		send_item(OP_ADVANCE, 0, 0, 0);
		write_reg(CFG_EDGE, 7'd3);
		send_item(OP_ADVANCE, 0, 0, 0);
	endtask

	task automatic random_phase(int n, logic [6:0] nr, logic [6:0] nc, logic [1:0] em);
		int lim_r;
		int lim_c;
		int pick;
		write_reg(CFG_ROWS, nr);
		write_reg(CFG_COLS, nc);
		write_reg(CFG_EDGE, 7'(em));
		lim_r = sat_count(nr, GRID_ROWS) - 1;
		lim_c = sat_count(nc, GRID_COLS) - 1;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				send_item(OP_WRITE, $urandom_range(0, lim_r), $urandom_range(0, lim_c),
					$urandom_range(0, 2) != 0);
			else if (pick < 8)
				send_item(OP_READ, $urandom_range(0, lim_r), $urandom_range(0, lim_c), 0);
			else if (pick < 9)
				send_item(OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
					1'($urandom_range(0, 1)));
			else
				send_item(2'($urandom_range(0, 3)), $urandom_range(0, 63),
					$urandom_range(0, 63), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_backpressure();
		drain();
		hold_long = 1;
		for (int i = 0; i < 6; i++)
			send_item(OP_READ, i, 2 * i, 0, 1);
		// sender holds until every result is back
		drain();
		for (int i = 0; i < 6; i++)
			send_item(OP_WRITE, 63 - i, i, i[0], 1);
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 16'd0;
		cfg_we        = 1'b0;
		cfg_index     = 2'd0;
		cfg_data      = 7'd0;
		err_count     = 0;
		hold_long     = 0;
		rand_sink     = 1;
		rows_reg      = 7'd64;
		cols_reg      = 7'd64;
		edge_reg      = EDGE_TORUS;
		for (int r = 0; r < GRID_ROWS; r++)
			life_grid[r] = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_edges_and_modes();
		test_small_grids();
		test_backpressure();
		random_phase(25, 7'd5, 7'd6, EDGE_TORUS);
		random_phase(25, 7'd8, 7'd3, EDGE_KLEIN);
		rand_sink = 0;
		random_phase(15, 7'd6, 7'd7, EDGE_DEAD);
		rand_sink = 1;
		random_phase(15, 7'd64, 7'd64, EDGE_KLEIN);
		random_phase(15, 7'd64, 7'd5, EDGE_TORUS);
		drain();

		if (err_count == 0 && cell_queue.size() == 0)
			$display("tb_life_generation_step: done, clean");
		else
			$display("tb_life_generation_step: done, errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_life_generation_step: done, errors");
		$finish;
	end

endmodule
